### rtl/core/fsr_pkg.sv
// fsr_pkg: shared types and constants for the float sum reduction block
// no dependencies; imported by fsr_fadd, fsr_store and float_sum_reduction
`default_nettype none
package fsr_pkg;

  localparam int unsigned AW = 6;               // address bits of a 64-entry store
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  // one read request into the stores, plus the write-back address it carries
  typedef struct packed {
    logic          valid;
    logic [AW-1:0] a_addr;   // accumulator address of the first operand
    logic [AW-1:0] b_addr;   // second operand address
    logic          b_gb;     // second operand from the group buffer, else accumulators
    logic [AW-1:0] dest;     // accumulator entry that takes the sum
  } rd_req_t;

endpackage
`default_nettype wire

### rtl/core/fsr_fadd.sv
// fsr_fadd: three-stage single-precision adder, round to nearest even
// depends on fsr_pkg for the NaN constants and address width
`default_nettype none
module fsr_fadd import fsr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_v,
  input  wire logic [AW-1:0] in_tag,
  input  wire logic [31:0]   a,
  input  wire logic [31:0]   b,
  output logic               res_v,
  output logic [AW-1:0]      res_tag,
  output logic [31:0]        res,
  output logic               pipe_busy
);

  // leading zeros of the low 27 bits, counted from bit 26
  function automatic logic [4:0] lzc27(input logic [26:0] x);
    logic [4:0] n;
    logic       hit;
    n   = 5'd27;
    hit = 1'b0;
    for (int k = 26; k >= 0; k--) begin
      if (!hit && x[k]) begin
        n   = 5'(26 - k);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // stage 1: specials, swap, alignment
  logic        nan_a, nan_b, inf_a, inf_b, swap;
  logic [31:0] big, sml, spec_val;
  logic [7:0]  eb, es, d;
  logic [26:0] mb, ms, ms_sh, lost_mask;
  logic [4:0]  sh_r1;

  always_comb begin
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:0] == 31'h7F80_0000);
    inf_b = (b[30:0] == 31'h7F80_0000);
    swap  = b[30:0] > a[30:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb    = {big[30:23] != 8'd0, big[22:0], 3'b000};
    ms    = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    d     = eb - es;
    sh_r1 = (d > 8'd27) ? 5'd27 : d[4:0];
    lost_mask = ~({27{1'b1}} << sh_r1);
    ms_sh = (ms >> sh_r1) | {26'd0, |(ms & lost_mask)};
    if (nan_a)                               spec_val = a | QUIET_BIT;
    else if (nan_b)                          spec_val = b | QUIET_BIT;
    else if (inf_a && inf_b && (a != b))     spec_val = DEFAULT_NAN;
    else if (inf_a)                          spec_val = a;
    else                                     spec_val = b;
  end

  logic          s1_v_r;
  logic [AW-1:0] s1_tag_r;
  logic          s1_spec_r, s1_sign_r, s1_sub_r;
  logic [31:0]   s1_spec_val_r;
  logic [7:0]    s1_e_r;
  logic [26:0]   s1_mb_r, s1_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_v;
    end
    s1_tag_r      <= in_tag;
    s1_spec_r     <= nan_a | nan_b | inf_a | inf_b;
    s1_spec_val_r <= spec_val;
    s1_sign_r     <= big[31];
    s1_sub_r      <= a[31] ^ b[31];
    s1_e_r        <= eb;
    s1_mb_r       <= mb;
    s1_ms_r       <= ms_sh;
  end

  // stage 2: add or subtract magnitudes, count leading zeros
  logic [27:0] sum2;
  assign sum2 = s1_sub_r ? ({1'b0, s1_mb_r} - {1'b0, s1_ms_r})
                         : ({1'b0, s1_mb_r} + {1'b0, s1_ms_r});

  logic          s2_v_r;
  logic [AW-1:0] s2_tag_r;
  logic          s2_spec_r, s2_sign_r, s2_sub_r;
  logic [31:0]   s2_spec_val_r;
  logic [7:0]    s2_e_r;
  logic [27:0]   s2_sum_r;
  logic [4:0]    s2_lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_tag_r      <= s1_tag_r;
    s2_spec_r     <= s1_spec_r;
    s2_spec_val_r <= s1_spec_val_r;
    s2_sign_r     <= s1_sign_r;
    s2_sub_r      <= s1_sub_r;
    s2_e_r        <= s1_e_r;
    s2_sum_r      <= sum2;
    s2_lz_r       <= lzc27(sum2[26:0]);
  end

  // stage 3: normalize, round, pack
  logic [7:0]  e_m1, nsh;
  logic [26:0] m3;
  logic [8:0]  e9;
  logic [7:0]  ef;
  logic        up;
  logic [30:0] mag;
  logic [31:0] res_nxt;

  always_comb begin
    e_m1 = s2_e_r - 8'd1;
    nsh  = ({3'd0, s2_lz_r} < e_m1) ? {3'd0, s2_lz_r} : e_m1;
    if (s2_sum_r[27]) begin
      m3 = {s2_sum_r[27:2], s2_sum_r[1] | s2_sum_r[0]};
      e9 = {1'b0, s2_e_r} + 9'd1;
    end else begin
      m3 = s2_sum_r[26:0] << nsh;
      e9 = {1'b0, s2_e_r} - {1'b0, nsh};
    end
    ef  = m3[26] ? e9[7:0] : 8'd0;
    up  = m3[2] & (m3[1] | m3[0] | m3[3]);
    mag = {ef, m3[25:3]} + {30'd0, up};
    if (s2_spec_r)                res_nxt = s2_spec_val_r;
    else if (e9 >= 9'd255)        res_nxt = {s2_sign_r, 8'hFF, 23'd0};
    else if (s2_sum_r == 28'd0)   res_nxt = {s2_sign_r & ~s2_sub_r, 31'd0};
    else                          res_nxt = {s2_sign_r, mag};
  end

  logic          res_v_r;
  logic [AW-1:0] res_tag_r;
  logic [31:0]   res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= s2_v_r;
    end
    res_tag_r <= s2_tag_r;
    res_r     <= res_nxt;
  end

  assign res_v     = res_v_r;
  assign res_tag   = res_tag_r;
  assign res       = res_r;
  assign pipe_busy = s1_v_r | s2_v_r | res_v_r;

endmodule
`default_nettype wire

### rtl/core/fsr_store.sv
// fsr_store: group buffer and accumulator memories with registered reads
// depends on fsr_pkg for rd_req_t; accumulators read as +0 until written
`default_nettype none
module fsr_store import fsr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          gb_we,
  input  wire logic [AW-1:0] gb_waddr,
  input  wire logic [31:0]   gb_wdata,
  input  wire rd_req_t       rd,
  input  wire logic          acc_we,
  input  wire logic [AW-1:0] acc_waddr,
  input  wire logic [31:0]   acc_wdata,
  input  wire logic          acc_clr,
  output logic               rd_v,
  output logic [AW-1:0]      rd_dest,
  output logic [31:0]        rd_a,
  output logic [31:0]        rd_b
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [31:0]      gb_mem  [DEPTH];
  logic [31:0]      acc_mem [DEPTH];
  logic [DEPTH-1:0] acc_ok_r;

  logic             rd_v_r, b_gb_r, a_ok_r, b_ok_r;
  logic [AW-1:0]    dest_r;
  logic [31:0]      a_raw_r, b_acc_r, b_gbd_r;

  // group buffer: one write port, one read port
  always_ff @(posedge clk) begin
    if (gb_we) begin
      gb_mem[gb_waddr] <= gb_wdata;
    end
    b_gbd_r <= gb_mem[rd.b_addr];
  end

  // accumulators: one write port, two read ports
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    a_raw_r <= acc_mem[rd.a_addr];
    b_acc_r <= acc_mem[rd.b_addr];
  end

  // written flags stand in for the +0 reset of the accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || acc_clr) begin
      acc_ok_r <= '0;
    end else if (acc_we) begin
      acc_ok_r[acc_waddr] <= 1'b1;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd.valid;
    end
    dest_r <= rd.dest;
    b_gb_r <= rd.b_gb;
    a_ok_r <= acc_ok_r[rd.a_addr];
    b_ok_r <= acc_ok_r[rd.b_addr];
  end

  assign rd_v    = rd_v_r;
  assign rd_dest = dest_r;
  assign rd_a    = a_ok_r ? a_raw_r : 32'd0;
  assign rd_b    = b_gb_r ? b_gbd_r : (b_ok_r ? b_acc_r : 32'd0);

endmodule
`default_nettype wire

### rtl/core/float_sum_reduction.sv
// float_sum_reduction: blocked single-precision sum of a stream of words
// depends on fsr_pkg, fsr_store, fsr_fadd
//
//   channel | ports                          | handshake
//   input   | in_value, in_last_item         | start high while busy low
//   result  | out_sum                        | out_valid strobe, one cycle
//
// A word that neither closes a group of 64 nor is the last only fills the buffer.
// The 64th word of a group starts a sweep of 64 read-add-write passes through
// the adder, one issued per cycle once the first has waited for the adder to drain.
// The last word starts the finish: block adds, tree and horizontal levels and
// leftover adds, each dependent step waiting for the adder pipeline to drain;
// out_sum follows once the last add has left the adder.
// Reset is synchronous; the result side cannot stall.
`default_nettype none
module float_sum_reduction import fsr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_value,
  input  wire logic        in_last_item,
  output logic             out_valid,
  output logic [31:0]      out_sum
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SWEEP = 4'd1;
  localparam logic [3:0] ST_BLK   = 4'd2;
  localparam logic [3:0] ST_T1    = 4'd3;
  localparam logic [3:0] ST_T2    = 4'd4;
  localparam logic [3:0] ST_T3    = 4'd5;
  localparam logic [3:0] ST_H1    = 4'd6;
  localparam logic [3:0] ST_H2    = 4'd7;
  localparam logic [3:0] ST_H3    = 4'd8;
  localparam logic [3:0] ST_LEFT  = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] m_r, m_nxt;
  logic          last_pend_r, last_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_sum_r, out_sum_nxt, last_res_r;

  rd_req_t       req;
  logic          acc_clr, accept, empty;
  logic          rd_v, res_v, fadd_busy;
  logic [AW-1:0] rd_dest, res_tag;
  logic [31:0]   rd_a, rd_b, res;

  // per-phase operation fields
  logic          active, need_drain, op_bgb;
  logic [AW-1:0] op_dest, op_b, last_idx, inc;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign empty  = !rd_v && !fadd_busy;
  assign inc    = fill_r + 6'd1;

  always_comb begin
    active     = 1'b1;
    need_drain = (idx_r == '0);
    op_bgb     = 1'b0;
    op_dest    = '0;
    op_b       = '0;
    last_idx   = '0;
    case (state_r)
      ST_SWEEP: begin
        op_dest = idx_r; op_b = idx_r; op_bgb = 1'b1; last_idx = 6'd63;
      end
      ST_BLK: begin
        op_dest = {3'b000, idx_r[2:0]}; op_b = idx_r; op_bgb = 1'b1;
        need_drain = (idx_r[2:0] == 3'd0);
        last_idx = {m_r[5:3], 3'b000} - 6'd1;
      end
      ST_T1: begin
        op_dest = {idx_r[4:3], 1'b0, idx_r[2:0]};
        op_b    = {idx_r[4:3], 1'b1, idx_r[2:0]};
        last_idx = 6'd31;
      end
      ST_T2: begin
        op_dest = {idx_r[3], 2'b00, idx_r[2:0]};
        op_b    = {idx_r[3], 2'b10, idx_r[2:0]};
        last_idx = 6'd15;
      end
      ST_T3: begin
        op_dest = {3'b000, idx_r[2:0]};
        op_b    = {3'b100, idx_r[2:0]};
        last_idx = 6'd7;
      end
      ST_H1: begin
        op_dest = {4'd0, idx_r[1:0]};
        op_b    = {3'd0, 1'b1, idx_r[1:0]};
        last_idx = 6'd3;
      end
      ST_H2: begin
        op_dest = {5'd0, idx_r[0]};
        op_b    = {4'd0, 1'b1, idx_r[0]};
        last_idx = 6'd1;
      end
      ST_H3: begin
        op_dest = 6'd0; op_b = 6'd1; last_idx = 6'd0;
      end
      ST_LEFT: begin
        op_dest = 6'd0; op_b = idx_r; op_bgb = 1'b1;
        need_drain = 1'b1;
        last_idx = m_r - 6'd1;
      end
      default: begin
        active = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    m_nxt         = m_r;
    last_pend_nxt = last_pend_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    acc_clr       = 1'b0;
    req           = '0;
    req.a_addr    = op_dest;
    req.b_addr    = op_b;
    req.b_gb      = op_bgb;
    req.dest      = op_dest;

    if (state_r == ST_IDLE) begin
      if (accept) begin
        fill_nxt = inc;
        idx_nxt  = '0;
        if (inc == '0) begin
          state_nxt     = ST_SWEEP;
          last_pend_nxt = in_last_item;
          m_nxt         = '0;
        end else if (in_last_item) begin
          m_nxt     = inc;
          state_nxt = (inc[5:3] != 3'd0) ? ST_BLK : ST_T1;
        end
      end
    end else if (state_r == ST_DONE) begin
      if (empty) begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = last_res_r;
        acc_clr       = 1'b1;
        fill_nxt      = '0;
        last_pend_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
    end else if (active && (!need_drain || empty)) begin
      req.valid = 1'b1;
      idx_nxt   = idx_r + 6'd1;
      if (idx_r == last_idx) begin
        idx_nxt = '0;
        case (state_r)
          ST_SWEEP: begin
            if (last_pend_r) begin
              state_nxt = (m_r[5:3] != 3'd0) ? ST_BLK : ST_T1;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ST_BLK:  state_nxt = ST_T1;
          ST_T1:   state_nxt = ST_T2;
          ST_T2:   state_nxt = ST_T3;
          ST_T3:   state_nxt = ST_H1;
          ST_H1:   state_nxt = ST_H2;
          ST_H2:   state_nxt = ST_H3;
          ST_H3: begin
            if (m_r[2:0] != 3'd0) begin
              state_nxt = ST_LEFT;
              idx_nxt   = {m_r[5:3], 3'b000};
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      fill_r      <= '0;
      m_r         <= '0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fill_r      <= fill_nxt;
      m_r         <= m_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_sum_r <= out_sum_nxt;
    if (res_v) begin
      last_res_r <= res;
    end
  end

  // memories
  fsr_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .gb_we     (accept),
    .gb_waddr  (fill_r),
    .gb_wdata  (in_value),
    .rd        (req),
    .acc_we    (res_v),
    .acc_waddr (res_tag),
    .acc_wdata (res),
    .acc_clr   (acc_clr),
    .rd_v      (rd_v),
    .rd_dest   (rd_dest),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // adder
  fsr_fadd u_fadd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (rd_v),
    .in_tag    (rd_dest),
    .a         (rd_a),
    .b         (rd_b),
    .res_v     (res_v),
    .res_tag   (res_tag),
    .res       (res),
    .pipe_busy (fadd_busy)
  );

  assign out_valid = out_valid_r;
  assign out_sum   = out_sum_r;

endmodule
`default_nettype wire

### rtl/core/fsr_checker.sv
// fsr_checker: port-level assertions for float_sum_reduction
// no package use; bound to the top level below
`default_nettype none
module fsr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_last_item,
  input wire logic        out_valid,
  input wire logic [31:0] out_sum
);

  // results come one cycle at a time
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // a result closes a busy stretch
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // the block is free again when the result shows
  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result shown");

  // a last word always starts the finish
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_item) |=> busy)
    else $error("last word did not start the finish");

  // no result right after accepting a word
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result straight after a word");

endmodule

bind float_sum_reduction fsr_checker u_fsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_last_item (in_last_item),
  .out_valid    (out_valid),
  .out_sum      (out_sum)
);
`default_nettype wire
